@@ hdl/hsort_pkg.sv @@
// Shared types and constants for the heap sorter.
// No dependencies; the files that use this package refer to it by scoped names.
`timescale 1ns / 1ps

package hsort_pkg;

  localparam int KEY_W = 48;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_PICK,
    ST_DEC,
    ST_SRT_RD0,
    ST_SRT_RDE,
    ST_SRT_SW,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

@@ hdl/hsort_mem.sv @@
// Heap key memory: one write port and one read port with registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module hsort_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 48
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/heap_sorter_top.sv @@
// Heap sorter top level: load, heap build, sort-down and emit sequencer.
// Depends on hsort_pkg and hsort_mem.
//
//   Channel   Handshake              Word
//   load      load_valid/load_stall  key, last
//   result    res_valid/res_stall    sorted_key, final_res, overflow
//
// Keys are stored as they arrive, up to MAX_ITEMS; the word marked last starts
// the sort. Each sift level uses ST_SIFT_L, ST_SIFT_R, ST_PICK (two children
// only) and ST_DEC on the single memory read port; ST_EMIT_RD/ST_EMIT_LD then
// emit the keys, waiting while the result register is stalled. The load side
// stalls from the last word until the final result is in the output register.
// Reset is synchronous and clears the control state; the key memory is never cleared.
`timescale 1ns / 1ps

module heap_sorter_top #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BYTES = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load_valid,
  output logic                     load_stall,
  input  logic [hsort_pkg::KEY_W-1:0] key,
  input  logic                     last,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [hsort_pkg::KEY_W-1:0] sorted_key,
  output logic                     final_res,
  output logic                     overflow
);

  localparam int KW    = hsort_pkg::KEY_W;
  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int KBITS = KEY_BYTES * 8;
  localparam logic [KW-1:0] KEY_MASK =
    (KBITS >= KW) ? {KW{1'b1}} : KW'((65'(1) << KBITS) - 65'(1));

  hsort_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          building, building_next;
  logic [AW-1:0] parent, parent_next;
  logic [AW-1:0] heap_end, heap_end_next;
  logic [AW-1:0] node, node_next;
  logic [AW-1:0] bottom, bottom_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] cand_idx, cand_idx_next;
  logic [KW-1:0] sift_val, sift_val_next;
  logic [KW-1:0] left_val, left_val_next;
  logic [KW-1:0] cand, cand_next;
  logic          res_valid_next;
  logic [KW-1:0] sorted_key_next;
  logic          final_res_next;
  logic          overflow_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rd_data;

  logic [AW:0]   child;
  logic          out_free;
  logic          sift_done;
  logic          is_final;

  assign child    = {node, 1'b1};
  assign out_free = !res_valid || !res_stall;
  assign is_final = ((CW'(idx) + CW'(1)) == count);

  hsort_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW),
    .W     (KW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    dropped_next    = dropped;
    building_next   = building;
    parent_next     = parent;
    heap_end_next   = heap_end;
    node_next       = node;
    bottom_next     = bottom;
    idx_next        = idx;
    cand_idx_next   = cand_idx;
    sift_val_next   = sift_val;
    left_val_next   = left_val;
    cand_next       = cand;
    res_valid_next  = res_valid && res_stall;
    sorted_key_next = sorted_key;
    final_res_next  = final_res;
    overflow_next   = overflow;
    wr_en           = 1'b0;
    wr_addr         = node;
    wr_data         = sift_val;
    rd_en           = 1'b0;
    rd_addr         = '0;
    sift_done       = 1'b0;
    load_stall      = (state != hsort_pkg::ST_LOAD);

    unique case (state)
      hsort_pkg::ST_LOAD: begin
        if (load_valid) begin
          if (count < CW'(MAX_ITEMS)) begin
            wr_en      = 1'b1;
            wr_addr    = count[AW-1:0];
            wr_data    = key & KEY_MASK;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            state_next = hsort_pkg::ST_PREP;
          end
        end
      end
      hsort_pkg::ST_PREP: begin
        if (count < CW'(2)) begin
          idx_next   = '0;
          state_next = hsort_pkg::ST_EMIT_RD;
        end else begin
          parent_next   = AW'((count >> 1) - CW'(1));
          bottom_next   = AW'(count - CW'(1));
          building_next = 1'b1;
          state_next    = hsort_pkg::ST_BLD_RD;
        end
      end
      hsort_pkg::ST_BLD_RD: begin
        rd_en      = 1'b1;
        rd_addr    = parent;
        node_next  = parent;
        state_next = hsort_pkg::ST_BLD_LD;
      end
      hsort_pkg::ST_BLD_LD: begin
        sift_val_next = rd_data;
        state_next    = hsort_pkg::ST_SIFT_L;
      end
      hsort_pkg::ST_SIFT_L: begin
        if (child > {1'b0, bottom}) begin
          wr_en     = 1'b1;
          sift_done = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = child[AW-1:0];
          state_next = hsort_pkg::ST_SIFT_R;
        end
      end
      hsort_pkg::ST_SIFT_R: begin
        if (child < {1'b0, bottom}) begin
          left_val_next = rd_data;
          rd_en         = 1'b1;
          rd_addr       = child[AW-1:0] + AW'(1);
          state_next    = hsort_pkg::ST_PICK;
        end else begin
          cand_next     = rd_data;
          cand_idx_next = child[AW-1:0];
          state_next    = hsort_pkg::ST_DEC;
        end
      end
      hsort_pkg::ST_PICK: begin
        if (left_val < rd_data) begin
          cand_next     = rd_data;
          cand_idx_next = child[AW-1:0] + AW'(1);
        end else begin
          cand_next     = left_val;
          cand_idx_next = child[AW-1:0];
        end
        state_next = hsort_pkg::ST_DEC;
      end
      hsort_pkg::ST_DEC: begin
        wr_en = 1'b1;
        if (sift_val > cand) begin
          sift_done = 1'b1;
        end else begin
          wr_data    = cand;
          node_next  = cand_idx;
          state_next = hsort_pkg::ST_SIFT_L;
        end
      end
      hsort_pkg::ST_SRT_RD0: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = hsort_pkg::ST_SRT_RDE;
      end
      hsort_pkg::ST_SRT_RDE: begin
        cand_next  = rd_data;
        rd_en      = 1'b1;
        rd_addr    = heap_end;
        state_next = hsort_pkg::ST_SRT_SW;
      end
      hsort_pkg::ST_SRT_SW: begin
        sift_val_next = rd_data;
        wr_en         = 1'b1;
        wr_addr       = heap_end;
        wr_data       = cand;
        node_next     = '0;
        bottom_next   = heap_end - AW'(1);
        state_next    = hsort_pkg::ST_SIFT_L;
      end
      hsort_pkg::ST_EMIT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = hsort_pkg::ST_EMIT_LD;
      end
      hsort_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          res_valid_next  = 1'b1;
          sorted_key_next = rd_data;
          final_res_next  = is_final;
          overflow_next   = dropped;
          if (is_final) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = hsort_pkg::ST_LOAD;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = hsort_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = hsort_pkg::ST_LOAD;
      end
    endcase

    if (sift_done) begin
      if (building) begin
        if (parent == '0) begin
          building_next = 1'b0;
          heap_end_next = bottom;
          state_next    = hsort_pkg::ST_SRT_RD0;
        end else begin
          parent_next = parent - AW'(1);
          state_next  = hsort_pkg::ST_BLD_RD;
        end
      end else if (heap_end == AW'(1)) begin
        idx_next   = '0;
        state_next = hsort_pkg::ST_EMIT_RD;
      end else begin
        heap_end_next = heap_end - AW'(1);
        state_next    = hsort_pkg::ST_SRT_RD0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hsort_pkg::ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      building  <= 1'b0;
      parent    <= '0;
      heap_end  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dropped   <= dropped_next;
      building  <= building_next;
      parent    <= parent_next;
      heap_end  <= heap_end_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    node       <= node_next;
    bottom     <= bottom_next;
    idx        <= idx_next;
    cand_idx   <= cand_idx_next;
    sift_val   <= sift_val_next;
    left_val   <= left_val_next;
    cand       <= cand_next;
    sorted_key <= sorted_key_next;
    final_res  <= final_res_next;
    overflow   <= overflow_next;
  end

endmodule

@@ verif/heap_sorter_checker.sv @@
// Scoreboard for the heap sorter: watches the load and result channels, keeps
// each run's keys in ascending order and compares every result word against it.
// Depends on hsort_pkg for the key width.
`timescale 1ns / 1ps

module heap_sorter_checker #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BYTES = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_valid,
  input  logic                        load_stall,
  input  logic [hsort_pkg::KEY_W-1:0] key,
  input  logic                        last,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  logic [hsort_pkg::KEY_W-1:0] sorted_key,
  input  logic                        final_res,
  input  logic                        overflow,
  output int                          errors,
  output int                          pending,
  output int                          runs_done,
  output int                          dropped_runs,
  output int                          words_checked
);

  localparam int KW = hsort_pkg::KEY_W;
  localparam logic [KW-1:0] KEY_MASK =
    (KEY_BYTES >= KW / 8) ? {KW{1'b1}} : ((KW'(1) << (8 * KEY_BYTES)) - KW'(1));

  typedef struct packed {
    logic [KW-1:0] sorted_key;
    logic          final_res;
    logic          overflow;
  } sorted_word_t;

  logic [KW-1:0] run_keys [0:MAX_ITEMS-1];
  int            run_len;
  logic          run_dropped;
  sorted_word_t  due_words [$];

  initial begin
    errors        = 0;
    pending       = 0;
    runs_done     = 0;
    dropped_runs  = 0;
    words_checked = 0;
    run_len       = 0;
    run_dropped   = 1'b0;
  end

  task automatic take_word(input logic [KW-1:0] k, input logic is_last);
    int            j;
    logic [KW-1:0] km;
    sorted_word_t  w;
    km = k & KEY_MASK;
    if (run_len < MAX_ITEMS) begin
      j = run_len;
      while (j > 0 && run_keys[j-1] > km) begin
        run_keys[j] = run_keys[j-1];
        j--;
      end
      run_keys[j] = km;
      run_len++;
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      for (j = 0; j < run_len; j++) begin
        w.sorted_key = run_keys[j];
        w.final_res  = (j == run_len - 1);
        w.overflow   = run_dropped;
        due_words.push_back(w);
      end
      runs_done++;
      if (run_dropped) dropped_runs++;
      run_len     = 0;
      run_dropped = 1'b0;
    end
  endtask

  task automatic check_word();
    sorted_word_t w;
    if (due_words.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual key %h final %b overflow %b",
               $time, sorted_key, final_res, overflow);
      errors++;
    end else begin
      w = due_words.pop_front();
      if (sorted_key !== w.sorted_key) begin
        $display("%0t: sorted_key mismatch, expected %h, actual %h",
                 $time, w.sorted_key, sorted_key);
        errors++;
      end
      if (final_res !== w.final_res) begin
        $display("%0t: final_res mismatch, expected %b, actual %b",
                 $time, w.final_res, final_res);
        errors++;
      end
      if (overflow !== w.overflow) begin
        $display("%0t: overflow mismatch, expected %b, actual %b",
                 $time, w.overflow, overflow);
        errors++;
      end
      words_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_len     = 0;
      run_dropped = 1'b0;
    end else begin
      if (load_valid && !load_stall) take_word(key, last);
      if (res_valid && !res_stall) check_word();
    end
    pending <= due_words.size();
  end

endmodule

@@ verif/tb_heap_sorter_top.sv @@
// Testbench top for the heap sorter: clock, reset, load stimulus and result back-pressure.
// Depends on hsort_pkg, heap_sorter_top and heap_sorter_checker, which does all checking.
`timescale 1ns / 1ps

module tb_heap_sorter_top;

  localparam int KW           = hsort_pkg::KEY_W;
  localparam int MAX_ITEMS    = 64;
  localparam int KEY_BYTES    = 6;
  localparam int ITEM_TARGET  = 370;
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE       = 64;

  typedef enum int {MIX_WIDE, MIX_FEW, MIX_PREFIX, MIX_EDGE} key_mix_t;

  localparam int DIR_RUNS [5] = '{1, 2, 4, 8, 6};
  localparam logic [KW-1:0] DIR_KEYS [21] = '{
    48'h0000_0000_0000,
    48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000,
    48'h0000_0000_0001, 48'h0000_0000_0001, 48'h0000_0000_0001, 48'h0000_0000_0001,
    48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
    48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFE,
    48'h4142_4300_0000, 48'h4142_4300_0001, 48'h4142_4400_0000, 48'h6162_0000_0000,
    48'h6162_0000_0100, 48'hFF00_0000_0000
  };

  logic          clk        = 1'b0;
  logic          rst        = 1'b1;
  logic          load_valid = 1'b0;
  logic          load_stall;
  logic [KW-1:0] key        = '0;
  logic          last       = 1'b0;
  logic          res_valid;
  logic          res_stall  = 1'b1;
  logic [KW-1:0] sorted_key;
  logic          final_res;
  logic          overflow;

  int errors, pending, runs_done, dropped_runs, words_checked;
  int hold_asked = 0;
  int hold_done  = 0;
  int burst_left = 0;
  bit quiet      = 1'b0;

  always #4 clk = ~clk;

  heap_sorter_top #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .load_valid(load_valid),
    .load_stall(load_stall),
    .key       (key),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sorted_key(sorted_key),
    .final_res (final_res),
    .overflow  (overflow)
  );

  heap_sorter_checker #(
    .MAX_ITEMS(MAX_ITEMS),
    .KEY_BYTES(KEY_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .key          (key),
    .last         (last),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .sorted_key   (sorted_key),
    .final_res    (final_res),
    .overflow     (overflow),
    .errors       (errors),
    .pending      (pending),
    .runs_done    (runs_done),
    .dropped_runs (dropped_runs),
    .words_checked(words_checked)
  );

  function automatic logic [KW-1:0] rand_word();
    logic [KW-1:0] w;
    w[47:32] = 16'($urandom_range(0, 16'hFFFF));
    w[31:0]  = $urandom();
    return w;
  endfunction

  function automatic logic [KW-1:0] pick_key(input key_mix_t mix, input logic [KW-1:0] base);
    logic [KW-1:0] w;
    w = rand_word();
    case (mix)
      MIX_WIDE:   return w;
      MIX_FEW:    return base ^ {w[47], 45'd0, w[1:0]};
      MIX_PREFIX: return {base[47:8], w[7:0]};
      default: begin
        case (w[1:0])
          2'd0:    return '0;
          2'd1:    return '1;
          2'd2:    return {47'd0, w[2]};
          default: return ~{47'd0, w[2]};
        endcase
      end
    endcase
  endfunction

  task automatic send_word(input logic [KW-1:0] k, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        load_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    load_valid <= 1'b1;
    key        <= k;
    last       <= is_last;
    @(posedge clk);
    while (load_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    load_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver back-pressure: random modes, plus one long hold-off on request.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= ($urandom_range(0, 3) == 0);
        default: res_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    int            items;
    int            set_no;
    int            len;
    int            idx;
    int            r;
    int            i;
    int            j;
    key_mix_t      mix;
    logic [KW-1:0] base;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idx = 0;
    for (r = 0; r < 5; r++) begin
      for (j = 0; j < DIR_RUNS[r]; j++) begin
        send_word(DIR_KEYS[idx], j == DIR_RUNS[r] - 1);
        idx++;
      end
    end
    items = idx;
    drain_results();

    // The first three runs fill the store exactly, overfill it by the last word,
    // and overfill it by several words.
    set_no = 0;
    while (items < ITEM_TARGET) begin
      case (set_no)
        0: len = MAX_ITEMS;
        1: len = MAX_ITEMS + 1;
        2: len = MAX_ITEMS + 6;
        default: begin
          r = $urandom_range(0, 19);
          len = (r < 16) ? $urandom_range(1, 12) :
                (r < 19) ? $urandom_range(13, 40) : $urandom_range(41, MAX_ITEMS + 6);
        end
      endcase
      mix   = key_mix_t'($urandom_range(0, 3));
      base  = rand_word();
      quiet = ($urandom_range(0, 3) == 0);
      if (set_no == 5) hold_asked <= hold_asked + 1;
      if (set_no == 14) drain_results();
      for (i = 0; i < len; i++) send_word(pick_key(mix, base), i == len - 1);
      items += len;
      set_no++;
    end
    drain_results();

    $display("Sorted %0d runs of 1 to %0d keys, %0d of them with dropped keys; %0d words checked.",
             runs_done, MAX_ITEMS + 6, dropped_runs, words_checked);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
